// ===== rtl/font_metrics_parser_assert.svh =====
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef FONT_METRICS_PARSER_ASSERT_SVH
`define FONT_METRICS_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define FMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fmp assertion failed");

`define FMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmp assertion failed");

`else

`define FMP_ASSERT_IMP(lbl, ante, cons)

`define FMP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/fmp_pkg.sv =====
package fmp_pkg;

  // header layout: last byte of each big-endian word and of the header
  localparam logic [4:0] HDR_COUNT_END   = 5'd3;
  localparam logic [4:0] HDR_VADV_END    = 5'd7;
  localparam logic [4:0] HDR_ASCENT_END  = 5'd11;
  localparam logic [4:0] HDR_DESCENT_END = 5'd15;
  localparam logic [4:0] HDR_LAST        = 5'd23;

  // glyph record layout
  localparam logic [4:0] REC_WIDTH_END = 5'd11;
  localparam logic [4:0] REC_ADV_END   = 5'd15;
  localparam logic [4:0] REC_COUNT_END = 5'd19;
  localparam logic [4:0] REC_LAST      = 5'd27;

  localparam logic [9:0]  IDX_MAX     = 10'd1023;
  localparam logic [31:0] MAX_GLYPHS  = 32'd1000;
  localparam logic [31:0] VAL_LIMIT   = 32'd100;
  localparam logic [6:0]  DEF_WIDTH   = 7'd6;
  localparam logic [30:0] DEF_HEIGHT  = 31'd9;

  localparam int unsigned OUT_BITS = 40;

  typedef struct packed {
    logic        ok;
    logic [31:0] vert_adv;
    logic [31:0] ascent;
    logic [31:0] descent;
    logic [6:0]  widest_glyph;
    logic [6:0]  widest_advance;
  } fmp_summary_t;

  function automatic logic [6:0] below_limit(input logic [31:0] w);
    below_limit = (w < VAL_LIMIT) ? w[6:0] : 7'd0;
  endfunction

endpackage

// ===== rtl/font_metrics_parser.sv =====
// Font metrics parser: takes a font blob one byte per transaction on the s_ side,
// with s_tlast on the final byte, and returns one result transaction per blob on
// the m_ side holding the ok flag, cell width and cell height. One byte is taken
// every clock cycle while s_tready is high; each byte makes one header/record state update.
// The summary register loads when the final byte is taken; the result moves on
// to the output register once it is free, and is offered on the m_ side. The input
// keeps flowing while only the output register holds a result; once a second
// finished blob waits in the summary register, s_tready stays low until the
// output side takes its result.
module font_metrics_parser
  import fmp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] data_byte
  input  logic                s_tlast,   // final_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata    // [0] metrics_ok, [7:1] cell_width,
                                         // [38:8] cell_height, [39] zero
);

  logic         sum_valid;
  logic         sum_take;
  fmp_summary_t summary;

  fmp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .ready      (s_tready),
    .sum_valid  (sum_valid),
    .summary    (summary),
    .sum_take   (sum_take)
  );

  fmp_result u_result (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .summary   (summary),
    .sum_take  (sum_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== rtl/fmp_parser.sv =====
`include "font_metrics_parser_assert.svh"

module fmp_parser
  import fmp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [7:0]   data_byte,
  input  logic         final_byte,
  output logic         ready,
  output logic         sum_valid,
  output fmp_summary_t summary,
  input  logic         sum_take
);

  logic [4:0]  byte_position, byte_position_next;
  logic        in_records, in_records_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] glyph_total, glyph_total_next;
  logic [31:0] vertical_advance, vertical_advance_next;
  logic [31:0] ascent_word, ascent_word_next;
  logic [31:0] descent_word, descent_word_next;
  logic [9:0]  record_index, record_index_next;
  logic [6:0]  pending_width, pending_width_next;
  logic [6:0]  pending_advance, pending_advance_next;
  logic [6:0]  widest_glyph, widest_glyph_next;
  logic [6:0]  widest_advance, widest_advance_next;
  logic        accept;

  // the summary slot is the only thing that can hold up the input
  assign ready  = !sum_valid || sum_take;
  assign accept = in_valid && ready;

  always_comb begin
    word_shift_next       = {word_shift[23:0], data_byte};
    byte_position_next    = byte_position + 5'd1;
    in_records_next       = in_records;
    glyph_total_next      = glyph_total;
    vertical_advance_next = vertical_advance;
    ascent_word_next      = ascent_word;
    descent_word_next     = descent_word;
    record_index_next     = record_index;
    pending_width_next    = pending_width;
    pending_advance_next  = pending_advance;
    widest_glyph_next     = widest_glyph;
    widest_advance_next   = widest_advance;
    if (!in_records) begin
      case (byte_position)
        HDR_COUNT_END:   glyph_total_next      = word_shift_next;
        HDR_VADV_END:    vertical_advance_next = word_shift_next;
        HDR_ASCENT_END:  ascent_word_next      = word_shift_next;
        HDR_DESCENT_END: descent_word_next     = word_shift_next;
        default: ;
      endcase
      if (byte_position >= HDR_LAST) begin
        in_records_next    = 1'b1;
        byte_position_next = 5'd0;
      end
    end else begin
      if (byte_position == REC_WIDTH_END) begin
        pending_width_next = below_limit(word_shift_next);
      end else if (byte_position == REC_ADV_END) begin
        pending_advance_next = below_limit(word_shift_next);
      end else if (byte_position == REC_COUNT_END && {22'd0, record_index} < glyph_total) begin
        if (pending_width > widest_glyph) begin
          widest_glyph_next = pending_width;
        end
        if (pending_advance > widest_advance) begin
          widest_advance_next = pending_advance;
        end
      end
      if (byte_position >= REC_LAST) begin
        byte_position_next = 5'd0;
        if (record_index != IDX_MAX) begin
          record_index_next = record_index + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      byte_position    <= '0;
      in_records       <= 1'b0;
      word_shift       <= '0;
      glyph_total      <= '0;
      vertical_advance <= '0;
      ascent_word      <= '0;
      descent_word     <= '0;
      record_index     <= '0;
      pending_width    <= '0;
      pending_advance  <= '0;
      widest_glyph     <= '0;
      widest_advance   <= '0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      in_records       <= in_records_next;
      word_shift       <= word_shift_next;
      glyph_total      <= glyph_total_next;
      vertical_advance <= vertical_advance_next;
      ascent_word      <= ascent_word_next;
      descent_word     <= descent_word_next;
      record_index     <= record_index_next;
      pending_width    <= pending_width_next;
      pending_advance  <= pending_advance_next;
      widest_glyph     <= widest_glyph_next;
      widest_advance   <= widest_advance_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (accept && final_byte) begin
      sum_valid <= 1'b1;
    end else if (sum_take) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && final_byte) begin
      summary.ok             <= in_records_next && (glyph_total_next != 32'd0)
                                && (glyph_total_next <= MAX_GLYPHS);
      summary.vert_adv       <= vertical_advance_next;
      summary.ascent         <= ascent_word_next;
      summary.descent        <= descent_word_next;
      summary.widest_glyph   <= widest_glyph_next;
      summary.widest_advance <= widest_advance_next;
    end
  end

  `FMP_ASSERT_IMP(a_hdr_pos, !in_records, byte_position <= HDR_LAST)
  `FMP_ASSERT_IMP(a_rec_pos, in_records, byte_position <= REC_LAST)
  `FMP_ASSERT_NXT(a_final_clears, accept && final_byte,
                  byte_position == 5'd0 && !in_records && record_index == 10'd0)

endmodule

// ===== rtl/fmp_result.sv =====
`include "font_metrics_parser_assert.svh"

module fmp_result
  import fmp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sum_valid,
  input  fmp_summary_t        summary,
  output logic                sum_take,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata
);

  logic [31:0] asc_desc;
  logic [31:0] tallest;
  logic [30:0] height_calc;
  logic [6:0]  width_calc;
  logic        metrics_ok;
  logic [6:0]  cell_width;
  logic [30:0] cell_height;

  assign sum_take = sum_valid && (!m_tvalid || m_tready);

  always_comb begin
    asc_desc = summary.ascent + summary.descent;
    // a zero vertical advance falls back to ascent+descent, which max() gives anyway
    tallest  = (summary.vert_adv > asc_desc) ? summary.vert_adv : asc_desc;
    if (tallest == 32'd0 || tallest[31]) begin
      height_calc = DEF_HEIGHT;
    end else begin
      height_calc = tallest[30:0];
    end
    if (summary.widest_glyph != 7'd0) begin
      width_calc = summary.widest_glyph;
    end else if (summary.widest_advance != 7'd0) begin
      width_calc = summary.widest_advance;
    end else begin
      width_calc = DEF_WIDTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sum_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_take) begin
      metrics_ok  <= summary.ok;
      cell_width  <= summary.ok ? width_calc : 7'd0;
      cell_height <= summary.ok ? height_calc : 31'd0;
    end
  end

  assign m_tdata = {1'b0, cell_height, cell_width, metrics_ok};

  `FMP_ASSERT_NXT(a_take_loads, sum_take, m_tvalid)
  `FMP_ASSERT_IMP(a_bad_zero, m_tvalid && !metrics_ok,
                  cell_width == 7'd0 && cell_height == 31'd0)
  `FMP_ASSERT_IMP(a_good_nonzero, m_tvalid && metrics_ok,
                  cell_width != 7'd0 && cell_width < 7'd100 && cell_height != 31'd0)

endmodule

// ===== dv/font_metrics_parser_test.sv =====
module font_metrics_parser_test;
  import fmp_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic        metrics_ok;
    logic [6:0]  cell_width;
    logic [30:0] cell_height;
  } metrics_t;

  class font_scoreboard;
    logic [4:0]  pos;
    logic        in_rec;
    logic [31:0] shift_w;
    logic [31:0] blob_glyphs;
    logic [31:0] vadv;
    logic [31:0] ascent;
    logic [31:0] descent;
    logic [9:0]  rec_idx;
    logic [6:0]  pend_width;
    logic [6:0]  pend_adv;
    logic [6:0]  top_width;
    logic [6:0]  max_adv;
    metrics_t    metrics_q[$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned results_seen;
    int unsigned ok_seen;

    function new();
      clear_blob();
      errors = 0;
      bytes_seen = 0;
      results_seen = 0;
      ok_seen = 0;
    endfunction

    function void clear_blob();
      pos = '0;
      in_rec = 1'b0;
      shift_w = '0;
      blob_glyphs = '0;
      vadv = '0;
      ascent = '0;
      descent = '0;
      rec_idx = '0;
      pend_width = '0;
      pend_adv = '0;
      top_width = '0;
      max_adv = '0;
    endfunction

    // values of 100 or more count as zero
    function logic [6:0] usable(input logic [31:0] w);
      return (w < 32'd100) ? w[6:0] : 7'd0;
    endfunction

    function int pending();
      return metrics_q.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void note_byte(input logic [7:0] d, input logic last);
      metrics_t    m;
      logic [31:0] sum;
      logic [31:0] vert;
      logic [31:0] h;
      bytes_seen++;
      shift_w = {shift_w[23:0], d};
      if (!in_rec) begin
        case (pos)
          HDR_COUNT_END:   blob_glyphs = shift_w;
          HDR_VADV_END:    vadv = shift_w;
          HDR_ASCENT_END:  ascent = shift_w;
          HDR_DESCENT_END: descent = shift_w;
          default: ;
        endcase
        if (pos >= HDR_LAST) begin
          in_rec = 1'b1;
          pos = '0;
        end else begin
          pos = pos + 5'd1;
        end
      end else begin
        if (pos == REC_WIDTH_END) begin
          pend_width = usable(shift_w);
        end else if (pos == REC_ADV_END) begin
          pend_adv = usable(shift_w);
        end else if (pos == REC_COUNT_END && {22'd0, rec_idx} < blob_glyphs) begin
          if (pend_width > top_width) top_width = pend_width;
          if (pend_adv > max_adv) max_adv = pend_adv;
        end
        if (pos >= REC_LAST) begin
          pos = '0;
          if (rec_idx != IDX_MAX) rec_idx = rec_idx + 10'd1;
        end else begin
          pos = pos + 5'd1;
        end
      end
      if (last) begin
        m = '0;
        m.metrics_ok = in_rec && blob_glyphs != 0 && blob_glyphs <= MAX_GLYPHS;
        if (m.metrics_ok) begin
          sum = ascent + descent;
          vert = (vadv != 0) ? vadv : sum;
          h = (vert > sum) ? vert : sum;
          // zero or negative as a signed word falls back to the default
          if (h == 0 || h[31]) h = 32'd9;
          m.cell_height = h[30:0];
          if (top_width != 0) m.cell_width = top_width;
          else if (max_adv != 0) m.cell_width = max_adv;
          else m.cell_width = 7'd6;
        end
        metrics_q.push_back(m);
        clear_blob();
      end
    endfunction

    task check_result(input logic [OUT_BITS-1:0] tdata);
      metrics_t want;
      results_seen++;
      if (metrics_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no blob pending", tdata));
      end else begin
        want = metrics_q.pop_front();
        if (want.metrics_ok) ok_seen++;
        if (tdata[0] !== want.metrics_ok)
          report_mismatch($sformatf("metrics_ok %b, want %b", tdata[0], want.metrics_ok));
        if (tdata[7:1] !== want.cell_width)
          report_mismatch($sformatf("cell_width %0d, want %0d", tdata[7:1],
                                    want.cell_width));
        if (tdata[38:8] !== want.cell_height)
          report_mismatch($sformatf("cell_height %0d, want %0d", tdata[38:8],
                                    want.cell_height));
        if (tdata[39] !== 1'b0)
          report_mismatch("padding bit of m_tdata not zero");
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;   // [7:0] data_byte
  logic                s_tlast = 1'b0; // final_byte
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;        // [0] metrics_ok, [7:1] cell_width,
                                       // [38:8] cell_height, [39] zero

  font_scoreboard sb;
  logic [7:0]     blob[$];
  int             src_idle_pct = 0;
  int             snk_stall_pct = 0;
  int             quiet_cycles = 0;
  int unsigned    blobs_sent = 0;

  font_metrics_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("** font_metrics_parser: FAILED **");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task send_byte(input logic [7:0] d, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(d, last);
    @(negedge clk);
  endtask

  task send_blob();
    for (int i = 0; i < blob.size(); i++) send_byte(blob[i], i == blob.size() - 1);
    blobs_sent++;
  endtask

  task put_word(input logic [31:0] w);
    blob.push_back(w[31:24]);
    blob.push_back(w[23:16]);
    blob.push_back(w[15:8]);
    blob.push_back(w[7:0]);
  endtask

  task put_random(input int n);
    repeat (n) blob.push_back($urandom_range(255));
  endtask

  task start_blob(input logic [31:0] count, input logic [31:0] vert,
                  input logic [31:0] asc, input logic [31:0] desc);
    blob.delete();
    put_word(count);
    put_word(vert);
    put_word(asc);
    put_word(desc);
    put_random(8);
  endtask

  task put_record(input logic [31:0] w, input logic [31:0] adv);
    put_random(8);
    put_word(w);
    put_word(adv);
    put_random(12);
  endtask

  task trim_blob(input int n);
    while (blob.size() > n) void'(blob.pop_back());
  endtask

  function logic [31:0] pick_metric();
    case ($urandom_range(9))
      6:       return 32'd100;
      7:       return 32'd99;
      8:       return $urandom_range(100, 255);
      9:       return $urandom;
      default: return $urandom_range(0, 99);
    endcase
  endfunction

  function logic [31:0] pick_count();
    case ($urandom_range(19))
      14:      return 32'd0;
      15:      return 32'd1000;
      16:      return 32'd1001;
      17:      return $urandom_range(1, 1000);
      18:      return $urandom;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function logic [31:0] pick_height_word();
    case ($urandom_range(7))
      0, 1:    return 32'd0;
      5:       return $urandom;
      6:       return 32'h8000_0000 | $urandom;
      7:       return 32'hFFFF_FFFF - $urandom_range(0, 63);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  task build_random_blob();
    int kind;
    kind = $urandom_range(99);
    blob.delete();
    if (kind < 12) begin
      put_random($urandom_range(1, 30));
    end else if (kind < 22) begin
      put_random($urandom_range(24, 100));
    end else begin
      start_blob(pick_count(), pick_height_word(), pick_height_word(), pick_height_word());
      repeat ($urandom_range(0, 3)) put_record(pick_metric(), pick_metric());
      // trailing record cut somewhere inside
      if ($urandom_range(3) == 0) begin
        put_record(pick_metric(), pick_metric());
        trim_blob(blob.size() - $urandom_range(1, 27));
      end
    end
  endtask

  initial begin
    int phase_bytes;
    int phase_blobs;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // blob ends inside the header
    blob.delete();
    blob.push_back(8'hFF);
    send_blob();
    start_blob(32'd1, 32'd0, 32'd0, 32'd0);
    trim_blob(23);
    send_blob();
    // header only, all heights zero: default width and height
    start_blob(32'd1, 32'd0, 32'd0, 32'd0);
    send_blob();
    // zero glyph count and one above the limit
    start_blob(32'd0, 32'd10, 32'd5, 32'd5);
    put_record(32'd10, 32'd10);
    send_blob();
    start_blob(32'd1001, 32'd10, 32'd5, 32'd5);
    put_record(32'd10, 32'd10);
    send_blob();
    // largest glyph count, widths at and just past the top of the range
    start_blob(32'd1000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    put_record(32'd99, 32'd50);
    put_record(32'd100, 32'd99);
    send_blob();
    // no usable glyph width: falls back to advance
    start_blob(32'd2, 32'd20, 32'd10, 32'd30);
    put_record(32'd100, 32'd7);
    put_record(32'd0, 32'd150);
    send_blob();
    // second record stops one byte short of counting
    start_blob(32'd3, 32'd0, 32'hFFFF_FFF0, 32'h20);
    put_record(32'd10, 32'd0);
    put_record(32'd50, 32'd0);
    trim_blob(blob.size() - 9);
    send_blob();
    // same, but exactly enough bytes to count
    start_blob(32'd3, 32'h8000_0000, 32'd1, 32'd1);
    put_record(32'd10, 32'd0);
    put_record(32'd60, 32'd0);
    trim_blob(blob.size() - 8);
    send_blob();
    // record beyond the glyph count is ignored
    start_blob(32'd1, 32'd12, 32'd0, 32'd0);
    put_record(32'd5, 32'd5);
    put_record(32'd80, 32'd80);
    send_blob();
    // full glyph count with only a few records present
    start_blob(32'd1000, 32'd16, 32'd8, 32'd4);
    repeat (3) put_record(pick_metric(), pick_metric());
    send_blob();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
        default: begin src_idle_pct = 13; snk_stall_pct = 13; end
      endcase
      phase_bytes = 0;
      phase_blobs = 0;
      while (phase_bytes < 280 || phase_blobs < 4) begin
        build_random_blob();
        phase_bytes += blob.size();
        phase_blobs++;
        send_blob();
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("results still outstanding at end");

    $display("ran %0d blobs (%0d bytes), %0d results checked, %0d of them ok",
             blobs_sent, sb.bytes_seen, sb.results_seen, sb.ok_seen);
    $display("source idle and sink stall mixes: none, source, sink, both");
    if (sb.errors == 0) begin
      $display("** font_metrics_parser: PASSED **");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("** font_metrics_parser: FAILED **");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fmp_pkg.sv
rtl/fmp_parser.sv
rtl/fmp_result.sv
rtl/font_metrics_parser.sv
dv/font_metrics_parser_test.sv
